// ===== rtl/tic_pkg.sv =====
// ----------------------------------------------------------------------------
// tic_pkg: shared types and constants of the timer interval converter
// Field widths, derived datapath widths, command and register codes, and the
// request and response bundles of the serial multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tic_pkg;

  // Counter and prescaler geometry of the timer being served
  localparam int COUNT_BITS    = 24;
  localparam int PRESCALE_BITS = 8;

  localparam int VAL_W  = 32;                     // value and frequency fields
  localparam int PSC1_W = PRESCALE_BITS + 1;      // prescaler plus one
  localparam int DEN_W  = VAL_W + PRESCALE_BITS;  // freq*(p+1) or value*(p+1)
  localparam int NUM_W  = 2 * VAL_W + PRESCALE_BITS; // full product width
  localparam int CNT_W  = $clog2(NUM_W + 1);      // step counters

  localparam logic [PRESCALE_BITS-1:0] PRESCALE_MAX =
    PRESCALE_BITS'((32'd1 << PRESCALE_BITS) - 32'd1);
  localparam logic [VAL_W-1:0] COUNT_MAX = VAL_W'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [VAL_W-1:0] COUNT_MIN = VAL_W'(2);

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_CLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_FREQ   = 1'b1;
  localparam logic [VAL_W-1:0] CLOCK_RESET = 32'd48000000;
  localparam logic [VAL_W-1:0] FREQ_RESET  = 32'd1000000;

  // Commands
  localparam logic CMD_TO_COUNTS = 1'b0;
  localparam logic CMD_TO_TICKS  = 1'b1;

  typedef struct packed {
    logic             go;
    logic [DEN_W-1:0] mcand;
    logic [VAL_W-1:0] mplier;
    logic [CNT_W-1:0] nbits;
    logic [NUM_W-1:0] init;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
    logic             quot_hi;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/timer_interval_converter.sv =====
// ----------------------------------------------------------------------------
// timer_interval_converter: prescaler pick and tick/count conversion
// Derives the timer prescaler from the configured clock and tick frequency,
// then converts an interval in ticks to counts or counts back to ticks with
// round-half-up division, using one serial multiplier and one serial divider.
// ----------------------------------------------------------------------------
// Sequence: the divider forms clock / freq for the prescaler, the multiplier
//   applies (p+1) and then forms the full product, and a last divider pass
//   gives the result; a zero clock or frequency is answered at once. The
//   serial divider's 72-bit pass is the longest step.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: clears the sequencer and the strobe; clock and frequency registers
//   return to 48 MHz and 1 MHz. The receiver cannot stall a result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_interval_converter
  import tic_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [VAL_W-1:0]     cfg_wdata_i,
  // command channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 command_i,
  input  wire logic [VAL_W-1:0]     value_i,
  // result channel
  output logic                      result_valid_o,
  output logic [VAL_W-1:0]          result_value_o,
  output logic [PRESCALE_BITS-1:0]  prescaler_o,
  output logic                      clamped_o,
  output logic                      config_error_o
);

  // Sequencer states
  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_IDLE = 3'd0; // wait for a start beat
  localparam logic [STATE_W-1:0] ST_PSC  = 3'd1; // clock / freq for prescaler
  localparam logic [STATE_W-1:0] ST_MUL1 = 3'd2; // times (prescaler + 1)
  localparam logic [STATE_W-1:0] ST_MUL2 = 3'd3; // full product plus rounding
  localparam logic [STATE_W-1:0] ST_DIV  = 3'd4; // final quotient

  logic [STATE_W-1:0]       state_q, state_d;

  // Configuration
  logic [VAL_W-1:0]         clock_q, freq_q;

  // Item context
  logic                     cmd_q;
  logic [VAL_W-1:0]         val_q;
  logic                     err_q;
  logic [PRESCALE_BITS-1:0] psc_q, psc_d;
  logic [DEN_W-1:0]         den_q, den_d;

  // Result beat
  logic                     valid_q, valid_d;
  logic [VAL_W-1:0]         res_q, res_d;
  logic [PRESCALE_BITS-1:0] psc_out_q, psc_out_d;
  logic                     clamped_q, clamped_d;
  logic                     err_out_q, err_out_d;

  // Arithmetic units
  mul_req_t                 mul_req;
  mul_rsp_t                 mul_rsp;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic                     accept;
  logic                     cfg_zero;
  logic                     cfg_err;

  logic [VAL_W-1:0]         q_half, q_bound, q_base;
  logic                     q_fit;
  logic [PRESCALE_BITS-1:0] psc_calc;
  logic [PSC1_W-1:0]        psc_inc;

  logic                     too_big, too_small;

  tic_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  tic_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign cfg_zero = (clock_q == '0) || (freq_q == '0);
  assign cfg_err  = cfg_zero || (freq_q > (clock_q >> 1));

  // Prescaler from Q = clock / freq.
  // The smallest p with clock/((p+1)*freq) inside the counter is Q >> COUNT_BITS;
  // the upper limit is Q/2 minus one (clock/(2*freq) - 1), capped at the max.
  assign q_half   = div_rsp.quot >> 1;
  assign q_bound  = (q_half != '0) ? (q_half - VAL_W'(1)) : '0;
  assign q_base   = div_rsp.quot >> COUNT_BITS;
  assign q_fit    = (q_base <= q_bound) && (q_base <= VAL_W'(PRESCALE_MAX));
  assign psc_calc = q_fit ? q_base[PRESCALE_BITS-1:0] : PRESCALE_MAX;
  assign psc_inc  = {1'b0, psc_calc} + PSC1_W'(1);

  // Saturation of the ticks-to-counts quotient, judged on the full quotient
  assign too_big   = div_rsp.quot_hi || (div_rsp.quot > COUNT_MAX);
  assign too_small = !div_rsp.quot_hi && (div_rsp.quot < COUNT_MIN);

  always_comb begin
    state_d   = state_q;
    psc_d     = psc_q;
    den_d     = den_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    psc_out_d = psc_out_q;
    clamped_d = clamped_q;
    err_out_d = err_out_q;
    mul_req   = '0;
    div_req   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cfg_zero) begin
            // nothing to convert: answer at once
            valid_d   = 1'b1;
            res_d     = '0;
            psc_out_d = (clock_q == '0) ? '0 : PRESCALE_MAX;
            clamped_d = 1'b0;
            err_out_d = 1'b1;
          end else begin
            // clock aligned to the top of the dividend, 32 steps
            div_req.go    = 1'b1;
            div_req.num   = {clock_q, {DEN_W{1'b0}}};
            div_req.den   = DEN_W'(freq_q);
            div_req.nbits = CNT_W'(VAL_W);
            state_d       = ST_PSC;
          end
        end
      end

      ST_PSC: begin
        if (div_rsp.done) begin
          psc_d          = psc_calc;
          mul_req.go     = 1'b1;
          mul_req.mcand  = (cmd_q == CMD_TO_TICKS) ? DEN_W'(val_q) : DEN_W'(freq_q);
          mul_req.mplier = VAL_W'(psc_inc);
          mul_req.nbits  = CNT_W'(PSC1_W);
          mul_req.init   = '0;
          state_d        = ST_MUL1;
        end
      end

      ST_MUL1: begin
        if (mul_rsp.done) begin
          mul_req.go    = 1'b1;
          mul_req.nbits = CNT_W'(VAL_W);
          if (cmd_q == CMD_TO_COUNTS) begin
            // clock * value + den/2, den = freq * (p+1)
            den_d          = mul_rsp.prod[DEN_W-1:0];
            mul_req.mcand  = DEN_W'(clock_q);
            mul_req.mplier = val_q;
            mul_req.init   = NUM_W'(mul_rsp.prod[DEN_W-1:1]);
          end else begin
            // value * (p+1) * freq + clock/2
            mul_req.mcand  = mul_rsp.prod[DEN_W-1:0];
            mul_req.mplier = freq_q;
            mul_req.init   = NUM_W'(clock_q[VAL_W-1:1]);
          end
          state_d = ST_MUL2;
        end
      end

      ST_MUL2: begin
        if (mul_rsp.done) begin
          div_req.go    = 1'b1;
          div_req.num   = mul_rsp.prod;
          div_req.den   = (cmd_q == CMD_TO_COUNTS) ? den_q : DEN_W'(clock_q);
          div_req.nbits = CNT_W'(NUM_W);
          state_d       = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          valid_d   = 1'b1;
          psc_out_d = psc_q;
          err_out_d = err_q;
          if (cmd_q == CMD_TO_COUNTS) begin
            // clamp to the counter's usable range
            if (too_big) begin
              res_d = COUNT_MAX;
            end else if (too_small) begin
              res_d = COUNT_MIN;
            end else begin
              res_d = div_rsp.quot;
            end
            clamped_d = too_big || too_small;
          end else begin
            res_d     = div_rsp.quot;
            clamped_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      clock_q <= CLOCK_RESET;
      freq_q  <= FREQ_RESET;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INPUT_CLOCK: clock_q <= cfg_wdata_i;
          CFG_TICK_FREQ:   freq_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Item context and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      val_q <= value_i;
      err_q <= cfg_err;
    end
    psc_q     <= psc_d;
    den_q     <= den_d;
    res_q     <= res_d;
    psc_out_q <= psc_out_d;
    clamped_q <= clamped_d;
    err_out_q <= err_out_d;
  end

  assign result_valid_o = valid_q;
  assign result_value_o = res_q;
  assign prescaler_o    = psc_out_q;
  assign clamped_o      = clamped_q;
  assign config_error_o = err_out_q;

endmodule

`default_nettype wire

// ===== rtl/tic_mul.sv =====
// ----------------------------------------------------------------------------
// tic_mul: bit-serial shift-add multiplier
// Retires one multiplier bit per cycle, LSB first, into an accumulator that
// starts from a caller-supplied offset.
// ----------------------------------------------------------------------------
`default_nettype none

module tic_mul
  import tic_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mul_req_t req_i,
  output mul_rsp_t      rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] acc_q, acc_d;
  logic [NUM_W-1:0] mcand_q, mcand_d;
  logic [VAL_W-1:0] mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    done_d   = busy_q && (cnt_q == CNT_W'(1));
    if (req_i.go) begin
      busy_d   = 1'b1;
      cnt_d    = req_i.nbits;
      acc_d    = req_i.init;
      mcand_d  = NUM_W'(req_i.mcand);
      mplier_d = req_i.mplier;
    end else if (busy_q) begin
      // add the shifted multiplicand where the current bit is set
      acc_d    = acc_q + (mplier_q[0] ? mcand_q : '0);
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

// ===== rtl/tic_div.sv =====
// ----------------------------------------------------------------------------
// tic_div: bit-serial restoring divider
// Brings in one dividend bit per cycle, MSB first, and develops one quotient
// bit per cycle; quotient bits above the low word fold into a sticky flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tic_div
  import tic_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] quot_q, quot_d;
  logic             hi_q, hi_d;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    hi_d   = hi_q;
    done_d = busy_q && (cnt_q == CNT_W'(1));
    if (req_i.go) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quot_d = '0;
      hi_d   = 1'b0;
    end else if (busy_q) begin
      // trial subtract; keep the difference when it does not borrow
      rem_d  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_d  = num_q << 1;
      quot_d = {quot_q[VAL_W-2:0], ge};
      hi_d   = hi_q | quot_q[VAL_W-1];
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    hi_q   <= hi_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.quot    = quot_q;
  assign rsp_o.quot_hi = hi_q;

endmodule

`default_nettype wire
